// ===== sv/sukset_pkg.sv =====
// ----------------------------------------------------------------------------
// sukset_pkg
// Shared sizes, codes and control types of the sorted unique key set.
// ----------------------------------------------------------------------------
package sukset_pkg;

  localparam int CAPACITY = 64;
  localparam int KEY_BITS = 31;
  localparam int CNT_BITS = $clog2(CAPACITY + 1);
  localparam int IDX_BITS = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  // match flags are reduced in groups, one register per group
  localparam int GROUP    = 8;
  localparam int NGROUPS  = (CAPACITY + GROUP - 1) / GROUP;
  localparam int PAD_BITS = NGROUPS * GROUP;

  typedef logic [KEY_BITS-1:0] key_t;
  typedef logic [CNT_BITS-1:0] count_t;
  typedef logic [IDX_BITS-1:0] idx_t;

  typedef enum logic [1:0] {
    FUNC_INSERT = 2'd0,
    FUNC_DELETE = 2'd1,
    FUNC_RANGE  = 2'd2,
    FUNC_LIST   = 2'd3
  } func_t;

  typedef enum logic [2:0] {
    ST_KEY      = 3'd0,
    ST_INSERTED = 3'd1,
    ST_PRESENT  = 3'd2,
    ST_DELETED  = 3'd3,
    ST_ABSENT   = 3'd4,
    ST_FULL     = 3'd5,
    ST_NONE     = 3'd6
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CMP,
    S_RED,
    S_DEC,
    S_SCAN,
    S_FIN
  } state_t;

  typedef enum logic [2:0] {
    CELL_HOLD,
    CELL_COMPARE,
    CELL_INSERT,
    CELL_DELETE,
    CELL_ROTATE
  } cell_op_t;

  // broadcast control to every cell of the chain
  typedef struct packed {
    cell_op_t op;
    key_t     key;
  } cell_ctl_t;

endpackage

// ===== sv/sukset_if.sv =====
// ----------------------------------------------------------------------------
// sukset_if
// Valid/ready channels for requests and responses of the key set.
// ----------------------------------------------------------------------------
interface sukset_req_if;
  logic                valid;
  logic                ready;
  sukset_pkg::func_t   func;
  sukset_pkg::key_t    key;
  sukset_pkg::key_t    range_low;
  sukset_pkg::key_t    range_high;

  modport source (output valid, func, key, range_low, range_high, input ready);
  modport sink   (input valid, func, key, range_low, range_high, output ready);
endinterface

interface sukset_rsp_if;
  logic                valid;
  logic                ready;
  sukset_pkg::key_t    value;
  sukset_pkg::status_t status;
  logic                last;

  modport source (output valid, value, status, last, input ready);
  modport sink   (input valid, value, status, last, output ready);
endinterface

// ===== sv/sukset_cell.sv =====
// ----------------------------------------------------------------------------
// sukset_cell
// One slot of the sorted chain: holds a key, compares it with the broadcast
// key, and on insert, delete and rotate takes a neighbor's or the broadcast key.
// ----------------------------------------------------------------------------
module sukset_cell (
  input  logic                  clk,
  input  sukset_pkg::cell_ctl_t ctl,
  input  sukset_pkg::key_t      left_key,
  input  sukset_pkg::key_t      right_key,
  input  logic                  left_ge,
  input  logic                  occ,
  output sukset_pkg::key_t      stored,
  output logic                  ge,
  output logic                  eq
);

  // key slot and registered compare flags
  always_ff @(posedge clk) begin
    case (ctl.op)
      sukset_pkg::CELL_COMPARE: begin
        ge <= !(occ && (stored < ctl.key));
        eq <= occ && (stored == ctl.key);
      end
      sukset_pkg::CELL_INSERT: begin
        // cells above the insertion point shift up by one; the insertion point takes the key
        if (left_ge) begin
          stored <= left_key;
        end else if (ge) begin
          stored <= ctl.key;
        end
      end
      sukset_pkg::CELL_DELETE: begin
        // cells from the matching slot upward shift down by one
        if (ge) begin
          stored <= right_key;
        end
      end
      sukset_pkg::CELL_ROTATE: begin
        stored <= right_key;
      end
      default: begin
      end
    endcase
  end

endmodule

// ===== sv/sorted_unique_key_set_core.sv =====
// ----------------------------------------------------------------------------
// sorted_unique_key_set_core
// Ascending table of unique keys in a chain of cells, with insert, delete,
// range query and list operations.
// ----------------------------------------------------------------------------
// insert/delete: after the request is taken the cells compare (S_CMP), the match
//   flags are reduced (S_RED), and S_DEC stages the result once the output is free
// range/list: the chain rotates once through all CAPACITY cells, one step per
//   cycle while no held key waits for a busy output slot
// one request at a time; the next is taken once the previous result is staged
// reset (synchronous, rst high) empties the table; stored keys are not cleared
module sorted_unique_key_set_core (
  input  logic clk,
  input  logic rst,
  sukset_req_if.sink   req,
  sukset_rsp_if.source rsp
);

  localparam int CAPACITY = sukset_pkg::CAPACITY;
  localparam sukset_pkg::idx_t   IDX_MAX = sukset_pkg::idx_t'(CAPACITY - 1);
  localparam sukset_pkg::count_t CNT_MAX = sukset_pkg::count_t'(CAPACITY);

  sukset_pkg::state_t state, state_next;
  sukset_pkg::count_t count, count_next;
  sukset_pkg::idx_t   scan_idx, scan_idx_next;
  logic               pend_valid, pend_valid_next;
  sukset_pkg::key_t   pend_key, pend_key_next;

  sukset_pkg::func_t  func;
  sukset_pkg::key_t   key, range_low, range_high;

  logic                out_valid;
  sukset_pkg::key_t    out_value;
  sukset_pkg::status_t out_status;
  logic                out_last;

  logic                emit;
  sukset_pkg::key_t    emit_value;
  sukset_pkg::status_t emit_status;
  logic                emit_last;
  logic                out_free;

  sukset_pkg::cell_ctl_t       ctl;
  logic [CAPACITY-1:0]         ge, eq, occ;
  sukset_pkg::key_t            stored [CAPACITY];
  logic [sukset_pkg::PAD_BITS-1:0] eq_pad;
  logic [sukset_pkg::NGROUPS-1:0]  grp;
  logic                        hit;
  logic                        qualify;

  // chain of cells
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    sukset_pkg::key_t left_key;
    logic             left_ge;
    if (i == 0) begin : g_first
      assign left_key = stored[0];
      assign left_ge  = 1'b0;
    end else begin : g_rest
      assign left_key = stored[i-1];
      assign left_ge  = ge[i-1];
    end
    assign occ[i] = count > sukset_pkg::count_t'(i);

    sukset_cell u_cell (
      .clk       (clk),
      .ctl       (ctl),
      .left_key  (left_key),
      .right_key (stored[(i + 1) % CAPACITY]),
      .left_ge   (left_ge),
      .occ       (occ[i]),
      .stored    (stored[i]),
      .ge        (ge[i]),
      .eq        (eq[i])
    );
  end

  // match reduction: one register level over groups of cells
  assign eq_pad = sukset_pkg::PAD_BITS'(eq);
  always_ff @(posedge clk) begin
    for (int j = 0; j < sukset_pkg::NGROUPS; j++) begin
      grp[j] <= |eq_pad[j*sukset_pkg::GROUP +: sukset_pkg::GROUP];
    end
  end
  assign hit = |grp;

  // cell 0 holds the key at sorted position scan_idx during a rotation
  assign qualify = (sukset_pkg::count_t'(scan_idx) < count) &&
                   ((func == sukset_pkg::FUNC_LIST) ||
                    ((stored[0] > range_low) && (stored[0] < range_high)));

  assign out_free = !out_valid || rsp.ready;

  // next state, cell control and result staging
  always_comb begin
    state_next      = state;
    count_next      = count;
    scan_idx_next   = scan_idx;
    pend_valid_next = pend_valid;
    pend_key_next   = pend_key;
    ctl.op          = sukset_pkg::CELL_HOLD;
    ctl.key         = key;
    emit            = 1'b0;
    emit_value      = '0;
    emit_status     = sukset_pkg::ST_KEY;
    emit_last       = 1'b0;
    case (state)
      sukset_pkg::S_IDLE: begin
        if (req.valid) begin
          if ((req.func == sukset_pkg::FUNC_INSERT) ||
              (req.func == sukset_pkg::FUNC_DELETE)) begin
            state_next = sukset_pkg::S_CMP;
          end else begin
            state_next      = sukset_pkg::S_SCAN;
            scan_idx_next   = '0;
            pend_valid_next = 1'b0;
          end
        end
      end
      sukset_pkg::S_CMP: begin
        ctl.op     = sukset_pkg::CELL_COMPARE;
        state_next = sukset_pkg::S_RED;
      end
      sukset_pkg::S_RED: begin
        state_next = sukset_pkg::S_DEC;
      end
      sukset_pkg::S_DEC: begin
        if (out_free) begin
          emit       = 1'b1;
          emit_last  = 1'b1;
          state_next = sukset_pkg::S_IDLE;
          case (func)
            sukset_pkg::FUNC_INSERT: begin
              if (hit) begin
                emit_status = sukset_pkg::ST_PRESENT;
              end else if (count == CNT_MAX) begin
                emit_status = sukset_pkg::ST_FULL;
              end else begin
                ctl.op      = sukset_pkg::CELL_INSERT;
                count_next  = count + sukset_pkg::count_t'(1);
                emit_status = sukset_pkg::ST_INSERTED;
              end
            end
            sukset_pkg::FUNC_DELETE: begin
              if (hit) begin
                ctl.op      = sukset_pkg::CELL_DELETE;
                count_next  = count - sukset_pkg::count_t'(1);
                emit_status = sukset_pkg::ST_DELETED;
              end else begin
                emit_status = sukset_pkg::ST_ABSENT;
              end
            end
            default: begin
              emit_status = sukset_pkg::ST_NONE;
            end
          endcase
        end
      end
      sukset_pkg::S_SCAN: begin
        // one rotation step unless a held key must go out to a busy slot
        if (!(qualify && pend_valid && !out_free)) begin
          ctl.op        = sukset_pkg::CELL_ROTATE;
          scan_idx_next = scan_idx + sukset_pkg::idx_t'(1);
          if (qualify) begin
            if (pend_valid) begin
              emit       = 1'b1;
              emit_value = pend_key;
            end
            pend_valid_next = 1'b1;
            pend_key_next   = stored[0];
          end
          if (scan_idx == IDX_MAX) begin
            state_next = sukset_pkg::S_FIN;
          end
        end
      end
      sukset_pkg::S_FIN: begin
        // the held key is the final one; none held means nothing matched
        if (out_free) begin
          emit       = 1'b1;
          emit_last  = 1'b1;
          state_next = sukset_pkg::S_IDLE;
          if (pend_valid) begin
            emit_value = pend_key;
          end else begin
            emit_status = sukset_pkg::ST_NONE;
          end
          pend_valid_next = 1'b0;
        end
      end
      default: begin
        state_next = sukset_pkg::S_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= sukset_pkg::S_IDLE;
      count      <= '0;
      scan_idx   <= '0;
      pend_valid <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      state      <= state_next;
      count      <= count_next;
      scan_idx   <= scan_idx_next;
      pend_valid <= pend_valid_next;
      if (emit) begin
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    pend_key <= pend_key_next;
    if (req.valid && req.ready) begin
      func       <= req.func;
      key        <= req.key;
      range_low  <= req.range_low;
      range_high <= req.range_high;
    end
    if (emit) begin
      out_value  <= emit_value;
      out_status <= emit_status;
      out_last   <= emit_last;
    end
  end

  assign req.ready  = (state == sukset_pkg::S_IDLE);
  assign rsp.valid  = out_valid;
  assign rsp.value  = out_value;
  assign rsp.status = out_status;
  assign rsp.last   = out_last;

  // checks
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_MAX)
    else $error("key count above capacity");

  a_status_last: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && (rsp.status != sukset_pkg::ST_KEY) |-> rsp.last)
    else $error("status result not marked last");

  a_insert_grows: assert property (@(posedge clk) disable iff (rst)
    (state == sukset_pkg::S_DEC) && out_free && (func == sukset_pkg::FUNC_INSERT) &&
    !hit && (count != CNT_MAX) |=> count == $past(count) + sukset_pkg::count_t'(1))
    else $error("insert did not grow the table");

  a_scan_blocks: assert property (@(posedge clk) disable iff (rst)
    (state == sukset_pkg::S_SCAN) |-> !req.ready && (count == $past(count)))
    else $error("table changed or request taken during a scan");

endmodule
